// File: src/longest_unique_run_window_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef LONGEST_UNIQUE_RUN_WINDOW_DEFINES_SVH
`define LONGEST_UNIQUE_RUN_WINDOW_DEFINES_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define LURW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked at every edge
`define LURW_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define LURW_ASSERT(label, clk, rst, prop)
`define LURW_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: src/lurw_pkg.sv
// ---------------------------------------------------------------------------
// lurw_pkg
// Shared constants and types of the longest unique run window block.
// ---------------------------------------------------------------------------
`default_nettype none

package lurw_pkg;

  localparam int POS_BITS_DEF    = 16;
  localparam int SYMBOL_BITS_DEF = 8;
  localparam int CHAR_BITS       = 8;
  localparam int LEN_BITS        = 16;
  localparam int LEN_MAX         = (1 << LEN_BITS) - 1;

  typedef struct packed {
    logic [LEN_BITS-1:0] window_length;
    logic [LEN_BITS-1:0] best_length;
    logic                overflow;
  } result_t;

endpackage

`default_nettype wire

// File: src/lurw_mem.sv
// ---------------------------------------------------------------------------
// lurw_mem
// Last-seen position table: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module lurw_mem #(
  parameter int ADDR_BITS = lurw_pkg::SYMBOL_BITS_DEF,
  parameter int DATA_BITS = lurw_pkg::POS_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [DATA_BITS-1:0] rd_data,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0] wr_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/lurw_core.sv
// ---------------------------------------------------------------------------
// lurw_core
// Lookup stage: last-seen read, window update, seen bits and counters.
// ---------------------------------------------------------------------------
`default_nettype none

module lurw_core #(
  parameter int POS_BITS    = lurw_pkg::POS_BITS_DEF,
  parameter int SYMBOL_BITS = lurw_pkg::SYMBOL_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   take,
  input  wire logic [SYMBOL_BITS-1:0] sym_in,
  input  wire logic                   first_in,
  input  wire logic                   adv_ok,
  output logic                        busy,
  output logic                        adv,
  output lurw_pkg::result_t           res
);

  localparam int NSYM = 1 << SYMBOL_BITS;
  localparam int LW   = POS_BITS + 1;
  localparam int CW   = (LW > lurw_pkg::LEN_BITS + 1) ? LW : lurw_pkg::LEN_BITS + 1;
  localparam logic [CW-1:0] LEN_MAX_C = CW'(lurw_pkg::LEN_MAX);

  logic                   s1_valid;
  logic [SYMBOL_BITS-1:0] s1_sym;
  logic                   s1_first;
  logic                   fwd_hit;
  logic [POS_BITS-1:0]    fwd_pos;

  logic [POS_BITS-1:0]    pos;
  logic [POS_BITS-1:0]    start;
  logic [LW-1:0]          best;
  logic                   ovf;
  logic [NSYM-1:0]        seen;

  logic [POS_BITS-1:0]    rd_data;
  logic [POS_BITS-1:0]    pos_e;
  logic [POS_BITS-1:0]    start_e;
  logic [LW-1:0]          best_e;
  logic                   ovf_e;
  logic [POS_BITS-1:0]    last;
  logic                   hit;
  logic [POS_BITS-1:0]    ns_raw;
  logic [POS_BITS-1:0]    start_next;
  logic [LW-1:0]          win;
  logic [LW-1:0]          best_next;
  logic                   win_big;
  logic                   len_ovf;
  logic                   ovf_out;
  logic                   pos_sat;
  logic [POS_BITS-1:0]    pos_next;
  logic                   ovf_next;

  lurw_mem #(
    .ADDR_BITS (SYMBOL_BITS),
    .DATA_BITS (POS_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (sym_in),
    .rd_data (rd_data),
    .wr_en   (adv),
    .wr_addr (s1_sym),
    .wr_data (pos_e)
  );

  assign adv  = s1_valid && adv_ok;
  assign busy = s1_valid && !adv_ok;

  always_comb begin
    pos_e   = s1_first ? '0 : pos;
    start_e = s1_first ? '0 : start;
    best_e  = s1_first ? '0 : best;
    ovf_e   = s1_first ? 1'b0 : ovf;

    // write in flight to the same symbol beats the stale read
    last = fwd_hit ? fwd_pos : rd_data;
    hit  = !s1_first && seen[s1_sym] && (last >= start_e);

    if (hit) begin
      ns_raw = (last >= pos_e) ? pos_e : POS_BITS'(last + 1'b1);
    end else begin
      ns_raw = start_e;
    end
    start_next = (ns_raw > pos_e) ? pos_e : ns_raw;

    win       = LW'(pos_e) - LW'(start_next) + LW'(1);
    best_next = (win > best_e) ? win : best_e;
    win_big   = CW'(win) > LEN_MAX_C;
    len_ovf   = win_big || (CW'(best_next) > LEN_MAX_C);
    ovf_out   = ovf_e || len_ovf;
    pos_sat   = &pos_e;
    pos_next  = pos_sat ? pos_e : POS_BITS'(pos_e + 1'b1);
    ovf_next  = ovf_out || pos_sat;

    res.window_length = win_big ? lurw_pkg::LEN_BITS'(lurw_pkg::LEN_MAX)
                                : lurw_pkg::LEN_BITS'(CW'(win));
    res.best_length   = (CW'(best_next) > LEN_MAX_C) ?
                        lurw_pkg::LEN_BITS'(lurw_pkg::LEN_MAX) :
                        lurw_pkg::LEN_BITS'(CW'(best_next));
    res.overflow      = ovf_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sym   <= sym_in;
      s1_first <= first_in;
      fwd_hit  <= adv && (s1_sym == sym_in);
      fwd_pos  <= pos_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      start <= '0;
      best  <= '0;
      ovf   <= 1'b0;
      seen  <= '0;
    end else if (adv) begin
      pos   <= pos_next;
      start <= start_next;
      best  <= best_next;
      ovf   <= ovf_next;
      seen  <= (s1_first ? '0 : seen) | (NSYM'(1) << s1_sym);
    end
  end

endmodule

`default_nettype wire

// File: src/longest_unique_run_window.sv
// ---------------------------------------------------------------------------
// longest_unique_run_window
// Streaming longest repeat-free run over a byte string.
// ---------------------------------------------------------------------------
// Takes one byte per cycle, back to back, stalling only while a result word
// waits on a stalled output, and returns one result word per byte, through
// the lookup stage and output registers: the length of the repeat-free
// window ending at that byte, the longest such window so far in the string,
// and a sticky overflow flag. The rate is set by the last-seen position
// memory, one read and one write per cycle; a byte that repeats the one just
// before it takes the position from the write port by forwarding. Seen marks
// are flip-flops, cleared at once by first_of_string, so no clearing pass is
// needed. Only the low SYMBOL_BITS bits of char_byte are used.
`default_nettype none

`include "longest_unique_run_window_defines.svh"

module longest_unique_run_window #(
  parameter int POS_BITS    = lurw_pkg::POS_BITS_DEF,
  parameter int SYMBOL_BITS = lurw_pkg::SYMBOL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          char_valid,
  output logic                               char_stall,
  input  wire logic [lurw_pkg::CHAR_BITS-1:0] char_byte,
  input  wire logic                          first_of_string,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [lurw_pkg::LEN_BITS-1:0]      window_length,
  output logic [lurw_pkg::LEN_BITS-1:0]      best_length,
  output logic                               overflow
);

  logic                   take;
  logic                   adv;
  logic                   adv_ok;
  logic                   busy;
  logic [SYMBOL_BITS-1:0] sym;
  lurw_pkg::result_t      res;

  assign sym        = SYMBOL_BITS'(24'(char_byte));
  assign adv_ok     = !result_valid || !result_stall;
  assign char_stall = busy;
  assign take       = char_valid && !char_stall;

  lurw_core #(
    .POS_BITS    (POS_BITS),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .sym_in   (sym),
    .first_in (first_of_string),
    .adv_ok   (adv_ok),
    .busy     (busy),
    .adv      (adv),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      window_length <= res.window_length;
      best_length   <= res.best_length;
      overflow      <= res.overflow;
    end
  end

  `LURW_ASSERT(a_win_le_best, clk, rst, result_valid |-> (window_length <= best_length))
  `LURW_ASSERT(a_best_nonzero, clk, rst, result_valid |-> (best_length != '0))
  `LURW_ASSERT_ALWAYS(a_stall_cause, clk, char_stall |-> (result_valid && result_stall))

endmodule

`default_nettype wire

// File: sim/lurw_checker.sv
// ---------------------------------------------------------------------------
// lurw_checker
// Watches both channels of the longest unique run window block, predicts the
// lengths for each accepted word and compares every result word in order.
// ---------------------------------------------------------------------------
module lurw_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           char_valid,
  input  wire logic                           char_stall,
  input  wire logic [lurw_pkg::CHAR_BITS-1:0] char_byte,
  input  wire logic                           first_of_string,
  input  wire logic                           result_valid,
  input  wire logic                           result_stall,
  input  wire logic [lurw_pkg::LEN_BITS-1:0]  window_length,
  input  wire logic [lurw_pkg::LEN_BITS-1:0]  best_length,
  input  wire logic                           overflow,
  output int                                  fail_count,
  output int                                  pending
);
  import lurw_pkg::*;

  localparam int     POS_W   = POS_BITS_DEF;
  localparam int     SYM_N   = 1 << SYMBOL_BITS_DEF;
  localparam longint POS_TOP = (longint'(1) << POS_W) - 1;

  longint  last_pos [SYM_N];
  bit      seen [SYM_N];
  longint  cur_pos;
  longint  run_start;
  longint  best_run;
  bit      sat_flag;
  result_t length_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    foreach (last_pos[i]) last_pos[i] = 0;
  end

  function automatic void clear_string();
    foreach (seen[i]) seen[i] = 1'b0;
    cur_pos   = 0;
    run_start = 0;
    best_run  = 0;
    sat_flag  = 1'b0;
  endfunction

  function automatic result_t run_lengths(input logic [CHAR_BITS-1:0] ch, input logic first);
    int      sym;
    longint  win;
    result_t r;
    sym = int'(ch) % SYM_N;
    if (first) clear_string();
    if (seen[sym] && last_pos[sym] >= run_start)
      run_start = (last_pos[sym] >= cur_pos) ? cur_pos : last_pos[sym] + 1;
    if (run_start > cur_pos) run_start = cur_pos;
    last_pos[sym] = cur_pos;
    seen[sym]     = 1'b1;
    win = cur_pos - run_start + 1;
    if (win > best_run) best_run = win;
    if (win > LEN_MAX || best_run > LEN_MAX) sat_flag = 1'b1;
    r.window_length = LEN_BITS'((win > LEN_MAX) ? LEN_MAX : win);
    r.best_length   = LEN_BITS'((best_run > LEN_MAX) ? LEN_MAX : best_run);
    r.overflow      = sat_flag;
    // position sticks at its top value once saturated
    if (cur_pos >= POS_TOP) sat_flag = 1'b1;
    else cur_pos++;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_string();
      length_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (length_q.size() == 0) begin
          report("result word with none pending", 1, 0);
        end else begin
          want = length_q.pop_front();
          if (window_length !== want.window_length)
            report("window_length", longint'(window_length),
                   longint'(want.window_length));
          if (best_length !== want.best_length)
            report("best_length", longint'(best_length), longint'(want.best_length));
          if (overflow !== want.overflow)
            report("overflow", longint'(overflow), longint'(want.overflow));
        end
      end
      if (char_valid && !char_stall)
        length_q.push_back(run_lengths(char_byte, first_of_string));
    end
    pending = length_q.size();
  end

endmodule

// File: sim/tb_longest_unique_run_window.sv
// ---------------------------------------------------------------------------
// tb_longest_unique_run_window
// Drives strings into the block with random gaps and output stalls; a checker
// beside the block predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_longest_unique_run_window;
  import lurw_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic                 clk             = 1'b0;
  logic                 rst             = 1'b1;
  logic                 char_valid      = 1'b0;
  logic [CHAR_BITS-1:0] char_byte       = '0;
  logic                 first_of_string = 1'b0;
  logic                 result_stall    = 1'b0;
  logic                 char_stall;
  logic                 result_valid;
  logic [LEN_BITS-1:0]  window_length;
  logic [LEN_BITS-1:0]  best_length;
  logic                 overflow;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;
  bit hold_req    = 1'b0;

  always #5 clk = ~clk;

  longest_unique_run_window u_dut (
    .clk             (clk),
    .rst             (rst),
    .char_valid      (char_valid),
    .char_stall      (char_stall),
    .char_byte       (char_byte),
    .first_of_string (first_of_string),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .window_length   (window_length),
    .best_length     (best_length),
    .overflow        (overflow)
  );

  lurw_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .char_valid      (char_valid),
    .char_stall      (char_stall),
    .char_byte       (char_byte),
    .first_of_string (first_of_string),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .window_length   (window_length),
    .best_length     (best_length),
    .overflow        (overflow),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_word(input logic [CHAR_BITS-1:0] ch, input logic first);
    int gap;
    char_valid      <= 1'b1;
    char_byte       <= ch;
    first_of_string <= first;
    @(negedge clk);
    while (char_stall) @(negedge clk);
    @(posedge clk);
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_string(input string s, input bit open);
    for (int i = 0; i < s.len(); i++) send_word(s[i], open && i == 0);
  endtask

  task automatic drain();
    char_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // output side: alternating stall and go stretches, plus a long hold on request
  initial begin : rx_side
    int left;
    bit stalled;
    left    = 0;
    stalled = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stalled  = 1'b1;
        left     = 150;
      end else if (left > 0) begin
        left--;
      end else if (rx_quiet) begin
        stalled = 1'b0;
      end else begin
        stalled = !stalled;
        left    = stalled ? idle_len() : $urandom_range(0, 8);
      end
      result_stall <= stalled;
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("longest_unique_run_window test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int len;
    int alpha;
    int widths [5];
    logic [CHAR_BITS-1:0] base;
    bit open;
    widths = '{1, 2, 4, 16, 256};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // no start flag after reset, extremes, back-to-back repeats
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_string("abcabcbb", 1'b1);
    // earlier copy outside the window
    send_string("abba", 1'b1);
    // single-byte strings in a row
    send_word(8'h5A, 1'b1);
    send_word(8'h5A, 1'b1);
    send_word(8'hA5, 1'b1);
    send_word(8'h55, 1'b1);
    send_word(8'hAA, 1'b0);
    drain();

    // output held off while input keeps coming
    tx_quiet = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_word(CHAR_BITS'($urandom_range(0, 255)), i == 0);
    tx_quiet = 1'b0;
    drain();

    n = 0;
    while (n < 1200) begin
      len   = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 500) : $urandom_range(1, 40);
      alpha = widths[$urandom_range(0, 4)];
      base  = CHAR_BITS'($urandom_range(0, 255));
      open  = ($urandom_range(0, 9) != 0);
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < len; i++) begin
        send_word(base + CHAR_BITS'($urandom_range(0, alpha - 1)), open && i == 0);
        n++;
      end
      if ($urandom_range(0, 14) == 0) drain();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("longest_unique_run_window test passed");
    else
      $display("longest_unique_run_window test failed");
    $finish;
  end

endmodule
